// ===== src/nonzero_ring_average_unit_defines.svh =====
// ----------------------------------------------------------------------------
// nonzero_ring_average_unit_defines.svh
// Assertion macros shared by the moving-average RTL.
// ----------------------------------------------------------------------------
`ifndef NONZERO_RING_AVERAGE_UNIT_DEFINES_SVH
`define NONZERO_RING_AVERAGE_UNIT_DEFINES_SVH

// same-cycle implication
`define NRA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nra assertion failed");

// next-cycle implication
`define NRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nra assertion failed");

`endif

// ===== src/nra_pkg.sv =====
// ----------------------------------------------------------------------------
// nra_pkg
// Shared constants and controller command type for the moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package nra_pkg;

	localparam int DEPTH_DEFAULT = 1024;
	localparam int SAMPLE_W      = 16;
	localparam int COUNT_OUT_W   = 11;

	typedef struct packed {
		logic accept;     // latch sample, read oldest entry
		logic update;     // update sum/count, write ring, advance pointer
		logic div_start;  // load divider
		logic div_step;   // one quotient bit
		logic load_out;   // load result register
	} nra_cmd_t;

endpackage

`default_nettype wire

// ===== src/nra_datapath.sv =====
// ----------------------------------------------------------------------------
// nra_datapath
// Sample ring, running sum and count, serial divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nra_datapath #(
	parameter int DEPTH = nra_pkg::DEPTH_DEFAULT,
	parameter int SUM_W = $clog2(DEPTH) + 17
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire nra_pkg::nra_cmd_t                      cmd,
	input  wire logic signed [nra_pkg::SAMPLE_W-1:0]    sample,
	output logic signed [nra_pkg::SAMPLE_W-1:0]         average,
	output logic [nra_pkg::COUNT_OUT_W-1:0]             nonzero_count
);
	import nra_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [SAMPLE_W-1:0]        mem [DEPTH];
	logic [SAMPLE_W-1:0]        rd_q;
	logic [SAMPLE_W-1:0]        sample_s1;
	logic [PTR_W-1:0]           ptr_q;
	logic                       wrapped_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           count_q;
	logic [SUM_W-1:0]           quo_q;
	logic [CNT_W-1:0]           rem_q;
	logic                       neg_q;
	logic signed [SAMPLE_W-1:0] average_q;
	logic [COUNT_OUT_W-1:0]     nonzero_count_q;

	logic [SAMPLE_W-1:0]        removed;
	logic                       removed_nz;
	logic                       added_nz;
	logic signed [SUM_W-1:0]    removed_ext;
	logic signed [SUM_W-1:0]    added_ext;
	logic [SUM_W-1:0]           sum_mag;
	logic [CNT_W:0]             rem_shift;
	logic [CNT_W:0]             rem_diff;
	logic                       q_bit;
	logic [SUM_W-1:0]           quo_neg;
	logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

	// entries not yet written since reset read as zero
	assign removed     = wrapped_q ? rd_q : '0;
	assign removed_nz  = (removed != '0);
	assign added_nz    = (sample_s1 != '0);
	assign removed_ext = removed_nz ? {{(SUM_W-SAMPLE_W){removed[SAMPLE_W-1]}}, removed} : '0;
	assign added_ext   = {{(SUM_W-SAMPLE_W){sample_s1[SAMPLE_W-1]}}, sample_s1};
	assign sum_mag     = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign rem_shift   = {rem_q, quo_q[SUM_W-1]};
	assign rem_diff    = rem_shift - {1'b0, count_q};
	assign q_bit       = ~rem_diff[CNT_W];
	assign quo_neg     = ~quo_q + 1'b1;
	assign cnt_ext     = {{COUNT_OUT_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem[ptr_q] <= sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_s1 <= sample;
		end
		if (cmd.div_start) begin
			quo_q <= sum_mag;
			rem_q <= '0;
			neg_q <= sum_q[SUM_W-1];
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], q_bit};
			rem_q <= q_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
		end
		if (cmd.load_out) begin
			if (count_q == '0) begin
				average_q <= '0;
			end else if (neg_q) begin
				average_q <= quo_neg[SAMPLE_W-1:0];
			end else begin
				average_q <= quo_q[SAMPLE_W-1:0];
			end
			nonzero_count_q <= cnt_ext[COUNT_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
			count_q   <= '0;
		end else if (cmd.update) begin
			sum_q <= sum_q - removed_ext + (added_nz ? added_ext : '0);
			if (removed_nz && !added_nz && count_q != '0) begin
				count_q <= count_q - 1'b1;
			end else if (added_nz && !removed_nz) begin
				count_q <= count_q + 1'b1;
			end
			if (ptr_q == PTR_W'(DEPTH - 1)) begin
				ptr_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	assign average       = average_q;
	assign nonzero_count = nonzero_count_q;

endmodule

`default_nettype wire

// ===== src/nra_ctrl.sv =====
// ----------------------------------------------------------------------------
// nra_ctrl
// Sequencer for one sample: ring update, serial divide, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nonzero_ring_average_unit_defines.svh"

module nra_ctrl #(
	parameter int SUM_W = $clog2(nra_pkg::DEPTH_DEFAULT) + 17
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output nra_pkg::nra_cmd_t cmd
);
	import nra_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPD   = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [STEP_W-1:0] steps_q;
	logic              out_valid_q;
	logic              out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_START;
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (steps_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) begin
				steps_q <= STEP_W'(SUM_W - 1);
			end else if (cmd.div_step) begin
				steps_q <= steps_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`NRA_ASSERT_NEXT(a_accept_to_upd, clk, arst_n, in_valid && in_ready, state_q == ST_UPD)
	`NRA_ASSERT_IMPL(a_load_slot_free, clk, arst_n, cmd.load_out, !out_valid_q || out_ready)
	`NRA_ASSERT_NEXT(a_div_ends, clk, arst_n, state_q == ST_DIV && steps_q == '0, state_q == ST_DONE)
	`NRA_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load_out, out_valid_q)

endmodule

`default_nettype wire

// ===== src/nonzero_ring_average_unit.sv =====
// ----------------------------------------------------------------------------
// nonzero_ring_average_unit
// Moving mean of the nonzero samples among the last DEPTH samples.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one signed 16-bit sample per
// transaction. The sample replaces the oldest ring entry. Output channel
// out_valid/out_ready returns one transaction per sample: the mean of the
// nonzero stored samples (truncated toward zero, 0 if none) and their count.
// The controller steps through the update, divider start, serial divide and
// done states; SUM_W = clog2(DEPTH) + 17 is the width of the running sum
// and sets the length of the one-bit-per-cycle divider.
// A new sample is accepted only after the last result has been registered.
// A finished result waits in the output register; the next sample is taken
// and processed meanwhile, and only its handoff waits for out_ready.
// Reset clears sum, count, pointer and output valid at once; ring entries
// not yet written since reset read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module nonzero_ring_average_unit #(
	parameter int DEPTH = nra_pkg::DEPTH_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [nra_pkg::SAMPLE_W-1:0] sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [nra_pkg::SAMPLE_W-1:0]      average,
	output logic [nra_pkg::COUNT_OUT_W-1:0]          nonzero_count
);
	import nra_pkg::*;

	localparam int SUM_W = $clog2(DEPTH) + 17;

	nra_cmd_t cmd;

	nra_ctrl #(
		.SUM_W(SUM_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	nra_datapath #(
		.DEPTH(DEPTH),
		.SUM_W(SUM_W)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (sample),
		.average      (average),
		.nonzero_count(nonzero_count)
	);

endmodule

`default_nettype wire

// ===== test/nonzero_ring_average_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nonzero_ring_average_unit_test
// Self-checking bench for the nonzero moving-average ring.
// ----------------------------------------------------------------------------
// Samples go in through a bursty valid/ready sender. A local ring model
// tracks the stored samples, the running sum and the nonzero count, and it
// queues the expected mean and count for each accepted transaction. Every
// output transaction is compared with the oldest queued expectation while the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------

module nonzero_ring_average_unit_test;
	import nra_pkg::*;

	localparam int RING_DEPTH     = DEPTH_DEFAULT;
	localparam int RESULT_LATENCY = 40;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int RANDOM_SAMPLES = 330;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] average;
		logic [COUNT_OUT_W-1:0]     nonzero_count;
	} mean_result_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_LONG_STALL} rx_mode_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] average;
	logic [COUNT_OUT_W-1:0]     nonzero_count;

	// ring model
	logic signed [SAMPLE_W-1:0] ring_model [RING_DEPTH];
	int                         ring_wr_idx   = 0;
	longint                     ring_sum      = 0;
	int                         ring_nz_count = 0;
	mean_result_t               expected_means [$];

	int          fail_count      = 0;
	int          samples_sent    = 0;
	int          results_checked = 0;
	int          peak_count      = 0;
	int unsigned cycle_count     = 0;
	int          burst_left      = 0;
	int          gap_left        = 0;
	rx_mode_t    rx_mode         = RX_ALWAYS;
	int          rx_mode_left    = 0;
	int          rx_stall_left   = 0;

	nonzero_ring_average_unit #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.average      (average),
		.nonzero_count(nonzero_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** nonzero_ring_average_unit: FAILED **");
			$finish;
		end
	end

	// evict the oldest entry, store the new one, return the mean and count
	function automatic mean_result_t advance_ring(input logic signed [SAMPLE_W-1:0] s);
		mean_result_t               r;
		longint                     mean;
		logic signed [SAMPLE_W-1:0] evicted;
		evicted = ring_model[ring_wr_idx];
		if (evicted != 0) begin
			ring_sum = ring_sum - evicted;
			if (ring_nz_count > 0)
				ring_nz_count--;
		end
		if (s != 0) begin
			ring_sum = ring_sum + s;
			ring_nz_count++;
		end
		ring_model[ring_wr_idx] = s;
		ring_wr_idx = (ring_wr_idx + 1) % RING_DEPTH;
		mean = (ring_nz_count != 0) ? ring_sum / longint'(ring_nz_count) : 64'sd0;
		r.average       = mean[SAMPLE_W-1:0];
		r.nonzero_count = ring_nz_count[COUNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1:    return '0;
			2:       return 16'sh7FFF;
			3:       return 16'sh8000;
			4:       return ($urandom_range(0, 1) != 0)
				? $signed(16'($urandom_range(1, 8)))
				: -$signed(16'($urandom_range(1, 8)));
			default: return $signed(16'($urandom));
		endcase
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			case ($urandom_range(0, 3))
				0:       gap_left = 0;
				1:       gap_left = $urandom_range(1, 4);
				default: gap_left = $urandom_range(5, 60);
			endcase
		end
		if (gap_left > 0) begin
			in_valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		expected_means.push_back(advance_ring(s));
		samples_sent++;
		burst_left--;
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (expected_means.size() != 0)
			@(posedge clk);
	endtask

	// empty ring, zeros, full-scale values, truncation of negative means
	task automatic test_directed();
		logic signed [SAMPLE_W-1:0] pattern [] = '{
			16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, -16'sd1, -16'sd3, 16'sd0,
			16'sd1, 16'sd5, 16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh7FFF,
			16'sh8000, 16'sd0, 16'sd2, -16'sd7, 16'sd0, 16'sd100, -16'sd100
		};
		foreach (pattern[i])
			send_sample(pattern[i]);
		wait_results_drained();
	endtask

	// every entry nonzero at the negative limit, then eviction on wrap
	task automatic test_fill_minimum();
		repeat (RING_DEPTH)
			send_sample(16'sh8000);
		wait_results_drained();
	endtask

	task automatic test_random_mix();
		repeat (RANDOM_SAMPLES)
			send_sample(pick_sample());
		wait_results_drained();
	endtask

	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      = rx_mode_t'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(50, 600);
		end else begin
			rx_mode_left--;
		end
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
			RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
			default: begin
				if (rx_stall_left > 0) begin
					rx_stall_left--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						rx_stall_left = $urandom_range(20, 80);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		mean_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_means.size() == 0) begin
				$error("unexpected transaction: average=%0d nonzero_count=%0d",
					average, nonzero_count);
				fail_count++;
			end else begin
				want = expected_means.pop_front();
				results_checked++;
				if (average !== want.average) begin
					$error("average: expected %0d, got %0d",
						$signed(want.average), average);
					fail_count++;
				end
				if (nonzero_count !== want.nonzero_count) begin
					$error("nonzero_count: expected %0d, got %0d",
						want.nonzero_count, nonzero_count);
					fail_count++;
				end
				if (int'(nonzero_count) > peak_count)
					peak_count = int'(nonzero_count);
			end
		end
	end

	initial begin
		foreach (ring_model[i])
			ring_model[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_minimum();
		test_random_mix();

		repeat (RESULT_LATENCY) @(posedge clk);

		$display("%0d samples sent, %0d results checked, nonzero count peaked at %0d",
			samples_sent, results_checked, peak_count);
		$display("covered empty ring, zero samples, full-scale values and ring wraparound");
		if (fail_count == 0)
			$display("** nonzero_ring_average_unit: PASSED **");
		else
			$display("** nonzero_ring_average_unit: FAILED **");
		$finish;
	end

endmodule
